>>> src/rtsq_pkg.sv
`default_nettype none
package rtsq_pkg;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int FIELD_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int STREAM_W  = 8;
  localparam int CFG_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [STREAM_W-1:0] STREAM_SIZE_RESET = 8'd100;

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_STREAM_SIZE = 1'b0;

  // operations
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT   = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // store read address select
  localparam logic [2:0] RD_NONE       = 3'd0;
  localparam logic [2:0] RD_FRONT      = 3'd1;
  localparam logic [2:0] RD_SWAP       = 3'd2;
  localparam logic [2:0] RD_SCAN_FIRST = 3'd3;
  localparam logic [2:0] RD_SCAN_NEXT  = 3'd4;

  // store write select
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_NEW_P  = 3'd1;
  localparam logic [2:0] WR_MOVE_P = 3'd2;
  localparam logic [2:0] WR_NEW_Q  = 3'd3;
  localparam logic [2:0] WR_CANCEL = 3'd4;

  typedef struct packed {
    logic                latch;
    logic                div_start;
    logic [2:0]          rd_sel;
    logic [2:0]          wr_sel;
    logic                push;
    logic                pop;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                show_data;
    logic                out_load;
  } rtsq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_full;
    logic            is_empty;
    logic            div_done;
    logic            j_eq_n;
    logic            key_match;
    logic            scan_last;
    logic            out_free;
  } rtsq_stat_t;

endpackage
`default_nettype wire

>>> src/rtsq_ifs.sv
`default_nettype none
interface rtsq_req_if;
  import rtsq_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] event_key;
  logic [FIELD_W-1:0] event_handle;
  logic [FIELD_W-1:0] random_value;

  modport source (output valid, op, event_key, event_handle, random_value, input ready);
  modport sink (input valid, op, event_key, event_handle, random_value, output ready);
endinterface

interface rtsq_rsp_if;
  import rtsq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  out_key;
  logic [FIELD_W-1:0]  out_handle;
  logic                out_cancelled;
  logic                empty_flag;
  logic                full_flag;

  modport source (output valid, status, out_key, out_handle, out_cancelled, empty_flag,
                  full_flag, input ready);
  modport sink (input valid, status, out_key, out_handle, out_cancelled, empty_flag,
                full_flag, output ready);
endinterface
`default_nettype wire

>>> src/rtsq_mod.sv
`default_nettype none
module rtsq_mod #(
  parameter int DW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rtsq_pkg::FIELD_W-1:0] dividend,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [DW-1:0]               rem
);
  import rtsq_pkg::*;

  localparam int STEP  = 4;
  localparam int STEPS = FIELD_W / STEP;
  localparam int CNTW  = $clog2(STEPS);

  logic [FIELD_W-1:0] dq;
  logic [FIELD_W-1:0] dq_next;
  logic [DW-1:0]      dv;
  logic [DW-1:0]      rem_next;
  logic [DW:0]        trial;
  logic [CNTW-1:0]    cnt;
  logic               busy;

  // restoring division, four quotient bits per cycle; only the remainder is kept
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    trial    = '0;
    for (int k = 0; k < STEP; k++) begin
      trial = {rem_next, dq_next[FIELD_W-1]};
      if (trial >= {1'b0, dv}) begin
        rem_next = DW'(trial - {1'b0, dv});
      end else begin
        rem_next = trial[DW-1:0];
      end
      dq_next = {dq_next[FIELD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNTW'(1);
      if (cnt == CNTW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

>>> src/rtsq_dp.sv
`default_nettype none
module rtsq_dp #(
  parameter int DEPTH       = 128,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rtsq_pkg::OP_W-1:0]     op_in,
  input  logic [rtsq_pkg::FIELD_W-1:0]  key_in,
  input  logic [rtsq_pkg::FIELD_W-1:0]  handle_in,
  input  logic [rtsq_pkg::FIELD_W-1:0]  rnd_in,
  input  rtsq_pkg::rtsq_cmd_t           cmd,
  output rtsq_pkg::rtsq_stat_t          stat,
  input  logic                          cfg_we,
  input  logic [rtsq_pkg::STREAM_W-1:0] cfg_wdata,
  output logic [rtsq_pkg::STREAM_W-1:0] stream_size,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rtsq_pkg::STATUS_W-1:0] out_status,
  output logic [rtsq_pkg::FIELD_W-1:0]  out_key,
  output logic [rtsq_pkg::FIELD_W-1:0]  out_handle,
  output logic                          out_cancelled,
  output logic                          out_empty,
  output logic                          out_full
);
  import rtsq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int AW1 = AW + 1;
  localparam int CW  = ($clog2(DEPTH + 1) < STREAM_W) ? $clog2(DEPTH + 1) : STREAM_W;
  localparam int CW1 = CW + 1;

  logic [KEY_BITS-1:0]    key_mem    [DEPTH];
  logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
  logic                   canc_mem   [DEPTH];

  logic [OP_W-1:0]        op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [FIELD_W-1:0]     rnd_q;
  logic [STATUS_W-1:0]    status_q;
  logic                   show_q;

  logic [CW-1:0]          count;
  logic [AW-1:0]          front;
  logic [CW-1:0]          cap;
  logic [CW-1:0]          idx;
  logic [AW-1:0]          cur_addr;

  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   rd_canc;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   key_we;
  logic                   canc_we;
  logic [AW-1:0]          wr_addr;
  logic [KEY_BITS-1:0]    wr_key;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic                   wr_canc;

  logic [AW-1:0]          p_addr;
  logic [AW-1:0]          q_addr;
  logic [CW-1:0]          rem;
  logic                   div_done;

  logic [63:0]            key_x;
  logic [63:0]            handle_x;
  logic [63:0]            okey_x;
  logic [63:0]            ohandle_x;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= AW1'(DEPTH)) begin
      s = s - AW1'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign key_x     = 64'(key_in);
  assign handle_x  = 64'(handle_in);
  assign okey_x    = 64'(rd_key);
  assign ohandle_x = 64'(rd_handle);

  // capacity is the configured size saturated to the store depth
  always_comb begin
    if (32'(stream_size) >= DEPTH) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(stream_size);
    end
  end

  assign p_addr = wrap_add(front, AW'(count));
  assign q_addr = wrap_add(front, AW'(rem));

  rtsq_mod #(.DW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rnd_q),
    .divisor  (CW'(CW1'(count) + CW1'(1))),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    stat.op        = op_q;
    stat.is_full   = count >= cap;
    stat.is_empty  = count == '0;
    stat.div_done  = div_done;
    stat.j_eq_n    = rem == count;
    stat.key_match = rd_key == key_q;
    stat.scan_last = (CW1'(idx) + CW1'(1)) == CW1'(count);
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    rd_en   = cmd.rd_sel != RD_NONE;
    rd_addr = front;
    case (cmd.rd_sel)
      RD_SWAP:      rd_addr = q_addr;
      RD_SCAN_NEXT: rd_addr = wrap_add(cur_addr, AW'(1));
      default:      rd_addr = front;
    endcase
  end

  always_comb begin
    key_we    = 1'b0;
    canc_we   = 1'b0;
    wr_addr   = p_addr;
    wr_key    = key_q;
    wr_handle = handle_q;
    wr_canc   = 1'b0;
    case (cmd.wr_sel)
      WR_NEW_P: begin
        key_we  = 1'b1;
        canc_we = 1'b1;
      end
      WR_MOVE_P: begin
        key_we    = 1'b1;
        canc_we   = 1'b1;
        wr_key    = rd_key;
        wr_handle = rd_handle;
        wr_canc   = rd_canc;
      end
      WR_NEW_Q: begin
        key_we  = 1'b1;
        canc_we = 1'b1;
        wr_addr = cur_addr;
      end
      WR_CANCEL: begin
        canc_we = 1'b1;
        wr_addr = cur_addr;
        wr_canc = 1'b1;
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr]    <= wr_key;
      handle_mem[wr_addr] <= wr_handle;
    end
    if (canc_we) begin
      canc_mem[wr_addr] <= wr_canc;
    end
    if (rd_en) begin
      rd_key    <= key_mem[rd_addr];
      rd_handle <= handle_mem[rd_addr];
      rd_canc   <= canc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_addr <= rd_addr;
    end
    if (cmd.rd_sel == RD_SCAN_FIRST) begin
      idx <= '0;
    end else if (cmd.rd_sel == RD_SCAN_NEXT) begin
      idx <= idx + CW'(1);
    end
    if (cmd.latch) begin
      op_q     <= op_in;
      key_q    <= key_x[KEY_BITS-1:0];
      handle_q <= handle_x[HANDLE_BITS-1:0];
      rnd_q    <= rnd_in;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status;
      show_q   <= cmd.show_data;
    end
    if (cmd.out_load) begin
      out_status    <= status_q;
      out_key       <= show_q ? okey_x[FIELD_W-1:0] : '0;
      out_handle    <= show_q ? ohandle_x[FIELD_W-1:0] : '0;
      out_cancelled <= show_q & rd_canc;
      out_empty     <= count == '0;
      out_full      <= count >= cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      front       <= '0;
      stream_size <= STREAM_SIZE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
        front <= wrap_add(front, AW'(1));
      end
      // size changes only take effect on an empty queue
      if (cfg_we && count == '0) begin
        stream_size <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/rtsq_ctrl.sv
`default_nettype none
module rtsq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtsq_pkg::rtsq_stat_t stat,
  output rtsq_pkg::rtsq_cmd_t  cmd
);
  import rtsq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_INS_MOVE = 4'd3;
  localparam logic [3:0] S_INS_NEW  = 4'd4;
  localparam logic [3:0] S_FRONT    = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_FINISH   = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.is_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          OP_NEXT, OP_PEEK: begin
            if (stat.is_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_FINISH;
            end else begin
              cmd.rd_sel = RD_FRONT;
              state_next = S_FRONT;
            end
          end
          OP_CANCEL: begin
            if (stat.is_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOTFOUND;
              state_next     = S_FINISH;
            end else begin
              cmd.rd_sel = RD_SCAN_FIRST;
              state_next = S_SCAN;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.j_eq_n) begin
            cmd.wr_sel     = WR_NEW_P;
            cmd.push       = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_FINISH;
          end else begin
            cmd.rd_sel = RD_SWAP;
            state_next = S_INS_MOVE;
          end
        end
      end
      S_INS_MOVE: begin
        // old entry at the swap slot moves to the tail slot
        cmd.wr_sel = WR_MOVE_P;
        state_next = S_INS_NEW;
      end
      S_INS_NEW: begin
        cmd.wr_sel     = WR_NEW_Q;
        cmd.push       = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_next     = S_FINISH;
      end
      S_FRONT: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        cmd.show_data  = 1'b1;
        cmd.pop        = stat.op == OP_NEXT;
        state_next     = S_FINISH;
      end
      S_SCAN: begin
        if (stat.key_match) begin
          cmd.wr_sel     = WR_CANCEL;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_FINISH;
        end else if (stat.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_next     = S_FINISH;
        end else begin
          cmd.rd_sel = RD_SCAN_NEXT;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> src/random_tie_shuffle_event_queue.sv
`default_nettype none
// Channel  Direction  Handshake      Word
// req      in         valid / ready  op, event_key, event_handle, random_value
// rsp      out        valid / ready  status, out_key, out_handle, out_cancelled,
//                                    empty_flag, full_flag
// cfg      in         APB write/read stream_size at byte address 0
//
// One operation at a time: accept, dispatch, then any work, then finish.
// Insert: the remainder unit picks a slot; with a swap the old entry there moves to
// the tail. Next and peek: one store read. Cancel: scans from the front for the key.
// A refused or empty operation goes straight from dispatch to finish.
// Synchronous reset empties the queue and sets stream_size to 100; no store clearing.
// A result waiting in the output register does not block the next accept; a
// finished operation holds until that register is free.
module random_tie_shuffle_event_queue #(
  parameter int DEPTH       = 128,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  rtsq_req_if.sink                     req,
  rtsq_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtsq_pkg::PADDR_W-1:0] paddr,
  input  logic [rtsq_pkg::CFG_W-1:0]   pwdata,
  output logic [rtsq_pkg::CFG_W-1:0]   prdata,
  output logic                         pready
);
  import rtsq_pkg::*;

  rtsq_cmd_t           cmd;
  rtsq_stat_t          stat;
  logic [STREAM_W-1:0] stream_size;
  logic                reg_hit;
  logic                cfg_we;

  assign reg_hit = paddr[PADDR_W-1:2] == REG_STREAM_SIZE;
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_W'(stream_size) : '0;

  rtsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtsq_dp #(
    .DEPTH       (DEPTH),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op_in         (req.op),
    .key_in        (req.event_key),
    .handle_in     (req.event_handle),
    .rnd_in        (req.random_value),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[STREAM_W-1:0]),
    .stream_size   (stream_size),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_status    (rsp.status),
    .out_key       (rsp.out_key),
    .out_handle    (rsp.out_handle),
    .out_cancelled (rsp.out_cancelled),
    .out_empty     (rsp.empty_flag),
    .out_full      (rsp.full_flag)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.is_empty)
    else $error("pop issued on an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.is_full)
    else $error("push issued on a full queue");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result word overwritten before it was taken");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("remainder reported done right after start");

endmodule
`default_nettype wire
